// File: hw/rtl/c_token_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// Token classifier assertion macros
// Shared concurrent assertion forms for the token classifier checkers.
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH
`define C_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// Token classifier package
// Word types, codes, character constants and keyword tables of the classifier.
// ----------------------------------------------------------------------------
package ctc_pkg;

   localparam int MAX_TOKEN_LEN = 255;
   localparam int LEN_LIMIT_INT = (MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN;
   localparam logic [7:0] LEN_LIMIT = 8'(LEN_LIMIT_INT);

   localparam int NUM_KEYWORDS = 19;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   // Token classes.
   localparam logic [2:0] CLASS_KEYWORD      = 3'd0;
   localparam logic [2:0] CLASS_INTEGER      = 3'd1;
   localparam logic [2:0] CLASS_IDENTIFIER   = 3'd2;
   localparam logic [2:0] CLASS_UNIDENTIFIED = 3'd3;
   localparam logic [2:0] CLASS_OPERATOR     = 3'd4;

   // Single-character operator codes.
   localparam logic [2:0] OP_PLUS    = 3'd0;
   localparam logic [2:0] OP_MINUS   = 3'd1;
   localparam logic [2:0] OP_STAR    = 3'd2;
   localparam logic [2:0] OP_SLASH   = 3'd3;
   localparam logic [2:0] OP_EQUAL   = 3'd4;
   localparam logic [2:0] OP_GREATER = 3'd5;
   localparam logic [2:0] OP_LESS    = 3'd6;
   localparam logic [2:0] OP_BANG    = 3'd7;

   // Two-character operator codes.
   localparam logic [3:0] OP_EQ_EQ      = 4'd8;
   localparam logic [3:0] OP_NOT_EQ     = 4'd9;
   localparam logic [3:0] OP_GREATER_EQ = 4'd10;
   localparam logic [3:0] OP_LESS_EQ    = 4'd11;

   // Character codes.
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_DIGIT_0    = 8'h30;
   localparam logic [7:0] CH_DIGIT_9    = 8'h39;
   localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_GREATER    = 8'h3E;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LBRACKET   = 8'h5B;
   localparam logic [7:0] CH_RBRACKET   = 8'h5D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } ctc_req_type;

   typedef struct packed {
      logic [2:0]  token_class;
      logic [4:0]  keyword_number;
      logic [3:0]  operator_code;
      logic [15:0] token_start;
      logic [7:0]  token_length;
      logic        last_of_run;
   } ctc_rsp_type;

   typedef struct packed {
      logic [NUM_KEYWORDS-1:0] keyword_candidates;
      logic [7:0]              current_length;
      logic [15:0]             current_start;
      logic [15:0]             byte_position;
      logic                    digits_only;
      logic                    identifier_ok;
      logic                    pending_operator_valid;
      logic [2:0]              pending_operator_char;
      logic [15:0]             pending_operator_start;
   } ctc_state_type;

   // Up to two result words produced by one byte, in delivery order.
   typedef struct packed {
      logic [1:0]            count;
      ctc_rsp_type [1:0]     entry;
   } ctc_push_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] code;
   } ctc_op_type;

   localparam ctc_state_type STATE_RESET = '{
      keyword_candidates:     {NUM_KEYWORDS{1'b1}},
      current_length:         8'd0,
      current_start:          16'd0,
      byte_position:          16'd0,
      digits_only:            1'b1,
      identifier_ok:          1'b1,
      pending_operator_valid: 1'b0,
      pending_operator_char:  3'd0,
      pending_operator_start: 16'd0
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      case (c) inside
         CH_SPACE, CH_TAB, CH_NEWLINE, CH_COMMA, CH_SEMICOLON, CH_LPAREN,
         CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET: begin
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic ctc_op_type op_lookup(input logic [7:0] c);
      ctc_op_type r;
      r = '{valid: 1'b1, code: OP_PLUS};
      unique case (c)
         CH_PLUS:    r.code = OP_PLUS;
         CH_MINUS:   r.code = OP_MINUS;
         CH_STAR:    r.code = OP_STAR;
         CH_SLASH:   r.code = OP_SLASH;
         CH_EQUAL:   r.code = OP_EQUAL;
         CH_GREATER: r.code = OP_GREATER;
         CH_LESS:    r.code = OP_LESS;
         CH_BANG:    r.code = OP_BANG;
         default:    r.valid = 1'b0;
      endcase
      return r;
   endfunction

   // Code of the two-character operator formed by a held operator and '='.
   function automatic logic [3:0] pair_code(input logic [2:0] p);
      case (p)
         OP_EQUAL:   return OP_EQ_EQ;
         OP_BANG:    return OP_NOT_EQ;
         OP_GREATER: return OP_GREATER_EQ;
         OP_LESS:    return OP_LESS_EQ;
         default:    return {1'b0, p};
      endcase
   endfunction

   // Keyword spellings, right-justified, in list order.
   function automatic logic [63:0] kw_text(input int k);
      case (k)
         0:       return 64'("int");
         1:       return 64'("float");
         2:       return 64'("if");
         3:       return 64'("else");
         4:       return 64'("while");
         5:       return 64'("for");
         6:       return 64'("do");
         7:       return 64'("return");
         8:       return 64'("break");
         9:       return 64'("switch");
         10:      return 64'("case");
         11:      return 64'("char");
         12:      return 64'("double");
         13:      return 64'("void");
         14:      return 64'("long");
         15:      return 64'("short");
         16:      return 64'("struct");
         17:      return 64'("typedef");
         18:      return 64'("static");
         default: return 64'd0;
      endcase
   endfunction

   function automatic logic [2:0] kw_length(input int k);
      case (k)
         0, 5:                         return 3'd3;
         2, 6:                         return 3'd2;
         3, 10, 11, 13, 14:            return 3'd4;
         1, 4, 8, 15:                  return 3'd5;
         7, 9, 12, 16, 18:             return 3'd6;
         17:                           return 3'd7;
         default:                      return 3'd0;
      endcase
   endfunction

   // Character at position i of keyword k; meaningful only for i below its length.
   function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
      logic [63:0] txt;
      logic [2:0]  idx;
      txt = kw_text(k);
      idx = 3'(kw_length(k) - 3'd1 - i);
      return txt[8*idx +: 8];
   endfunction

endpackage

// File: hw/rtl/ctc_step.sv
// ----------------------------------------------------------------------------
// Token classifier step logic
// Handles one byte: next lexer state and up to two result words.
// ----------------------------------------------------------------------------
module ctc_step (
   input  ctc_pkg::ctc_state_type state,
   input  ctc_pkg::ctc_req_type   word,
   output ctc_pkg::ctc_state_type state_next,
   output ctc_pkg::ctc_push_type  push
);
   import ctc_pkg::*;

   logic [7:0]              c;
   ctc_op_type              op;
   logic                    sep;
   logic                    combine;
   logic                    add;
   logic [7:0]              len;
   logic [NUM_KEYWORDS-1:0] cand_added;
   ctc_state_type           tok_added;
   ctc_state_type           tok_src;
   logic                    emit_early;
   logic                    emit_token;
   logic                    emit_late;
   logic                    kw_found;
   logic [4:0]              kw_num;
   logic [2:0]              tok_class;
   ctc_rsp_type             r_early;
   ctc_rsp_type             r_token;
   ctc_rsp_type             r_late;

   always_comb begin
      c       = word.char_code;
      op      = op_lookup(c);
      sep     = is_separator(c);
      len     = state.current_length;
      combine = state.pending_operator_valid && (c == CH_EQUAL) &&
                (state.pending_operator_char >= OP_EQUAL);
      add     = !combine && !sep && !op.valid;

      // Token state after appending this byte.
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         cand_added[k] = state.keyword_candidates[k] &&
                         (len < 8'(kw_length(k))) &&
                         (kw_char(k, len[2:0]) == c);
      end
      tok_added = state;
      tok_added.keyword_candidates = cand_added;
      tok_added.digits_only = state.digits_only && is_digit(c);
      if (len == 8'd0) begin
         tok_added.current_start = state.byte_position;
         tok_added.identifier_ok = is_alpha(c) || (c == CH_UNDERSCORE);
      end else begin
         tok_added.identifier_ok = state.identifier_ok &&
                                   (is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE));
      end
      if (len < LEN_LIMIT) begin
         tok_added.current_length = len + 8'd1;
      end

      tok_src = add ? tok_added : state;

      emit_early = state.pending_operator_valid;
      emit_token = add ? word.end_of_input : (!combine && (len != 8'd0));
      emit_late  = word.end_of_input && !combine && op.valid;

      // Lowest-numbered keyword whose spelling still matches at full length.
      kw_found = 1'b0;
      kw_num   = 5'd0;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (tok_src.keyword_candidates[k] &&
             (tok_src.current_length == 8'(kw_length(k)))) begin
            kw_found = 1'b1;
            kw_num   = 5'(k);
         end
      end
      if (kw_found) begin
         tok_class = CLASS_KEYWORD;
      end else if (tok_src.digits_only) begin
         tok_class = CLASS_INTEGER;
      end else if (tok_src.identifier_ok) begin
         tok_class = CLASS_IDENTIFIER;
      end else begin
         tok_class = CLASS_UNIDENTIFIED;
      end

      r_early.token_class    = CLASS_OPERATOR;
      r_early.keyword_number = 5'd0;
      r_early.operator_code  = combine ? pair_code(state.pending_operator_char)
                                       : {1'b0, state.pending_operator_char};
      r_early.token_start    = state.pending_operator_start;
      r_early.token_length   = combine ? 8'd2 : 8'd1;
      r_early.last_of_run    = 1'b0;

      r_token.token_class    = tok_class;
      r_token.keyword_number = kw_found ? kw_num : 5'd0;
      r_token.operator_code  = 4'd0;
      r_token.token_start    = tok_src.current_start;
      r_token.token_length   = tok_src.current_length;
      r_token.last_of_run    = 1'b0;

      r_late.token_class     = CLASS_OPERATOR;
      r_late.keyword_number  = 5'd0;
      r_late.operator_code   = {1'b0, op.code};
      r_late.token_start     = state.byte_position;
      r_late.token_length    = 8'd1;
      r_late.last_of_run     = 1'b0;

      // At most two of the three can fire for one byte.
      push.count = 2'(emit_early) + 2'(emit_token) + 2'(emit_late);
      if (emit_early) begin
         push.entry[0] = r_early;
         push.entry[1] = emit_token ? r_token : r_late;
      end else begin
         push.entry[0] = emit_token ? r_token : r_late;
         push.entry[1] = r_late;
      end
      push.entry[0].last_of_run = (push.count == 2'd1);
      push.entry[1].last_of_run = (push.count == 2'd2);

      // Next state.
      state_next = add ? tok_added : state;
      if (!combine && (sep || op.valid)) begin
         state_next.keyword_candidates = STATE_RESET.keyword_candidates;
         state_next.current_length     = 8'd0;
         state_next.digits_only        = 1'b1;
         state_next.identifier_ok      = 1'b1;
      end
      state_next.pending_operator_valid = !combine && op.valid;
      if (!combine && op.valid) begin
         state_next.pending_operator_char  = op.code;
         state_next.pending_operator_start = state.byte_position;
      end
      state_next.byte_position = state.byte_position + 16'd1;
      if (word.end_of_input) begin
         state_next = STATE_RESET;
      end
   end

endmodule

// File: hw/rtl/ctc_rsp_queue.sv
// ----------------------------------------------------------------------------
// Token classifier result queue
// Small register queue; up to two words in a cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module ctc_rsp_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  ctc_pkg::ctc_push_type               push,
   output logic [ctc_pkg::QUEUE_CNT_W-1:0]     free_slots,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ctc_pkg::ctc_rsp_type                rsp_word
);
   import ctc_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] PTR_ONE = QUEUE_PTR_W'(1);
   localparam logic [QUEUE_CNT_W-1:0] DEPTH_COUNT = QUEUE_CNT_W'(QUEUE_DEPTH);

   ctc_rsp_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     pop;

   assign pop        = rsp_valid && !rsp_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_word   = entry_ff[rd_ptr_ff];
   assign free_slots = DEPTH_COUNT - count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + (pop ? PTR_ONE : '0);
      count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.entry[0];
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_ONE] <= push.entry[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/c_token_classifier_unit.sv
// ----------------------------------------------------------------------------
// Token classifier
// Splits a byte stream into tokens and reports the class of each token.
// ----------------------------------------------------------------------------
// Source bytes arrive one word at a time on the req_ channel; each word holds
// a character and an end-of-input flag that closes the expression. Results
// leave on the rsp_ channel, one word per token or operator, in text order;
// the final word caused by a given byte carries last_of_run. A byte may cause
// no result, one result or two.
// A byte is taken into an input register; once its results fit, a single
// combinational pass updates the lexer state and pushes its results into a
// four-word output queue. The first result word becomes valid once the pass
// has written it into the queue. One byte is accepted every cycle while
// each byte yields at most one word and the receiver does not stall; a byte
// that yields two words leaves the output channel an extra word to deliver,
// and the input stalls only when the queue cannot hold a byte's words.
// When the receiver stalls, the queue holds its head word steady and fills;
// when a byte's words no longer fit, the byte is held and req_stall is raised.
// Reset clears the queue, the input register and the lexer state, so the next
// byte is offset zero of a new expression. End of input resets only the lexer
// state, after flushing the open token and any held operator.
// ----------------------------------------------------------------------------
module c_token_classifier_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ctc_pkg::ctc_req_type  req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ctc_pkg::ctc_rsp_type  rsp_word
);
   import ctc_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   ctc_req_type             in_word_ff;
   ctc_state_type           state_ff, state_in;
   ctc_state_type           state_next;
   ctc_push_type            step_push;
   ctc_push_type            queue_push;
   logic [QUEUE_CNT_W-1:0]  free_slots;
   logic                    step_fire;
   logic                    req_take;

   // Combinational handling of the registered byte.
   ctc_step u_step (
      .state      (state_ff),
      .word       (in_word_ff),
      .state_next (state_next),
      .push       (step_push)
   );

   // The byte is processed only when every word it produces fits the queue.
   assign step_fire = in_valid_ff && (QUEUE_CNT_W'(step_push.count) <= free_slots);
   assign req_stall = in_valid_ff && !step_fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      queue_push       = step_push;
      queue_push.count = step_fire ? step_push.count : 2'd0;
      in_valid_in      = req_take || (in_valid_ff && !step_fire);
      state_in         = step_fire ? state_next : state_ff;
   end

   ctc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .free_slots (free_slots),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

endmodule

// File: hw/rtl/ctc_checker.sv
// ----------------------------------------------------------------------------
// Token classifier port checker
// Watches the result channel of the classifier for malformed words.
// ----------------------------------------------------------------------------
`include "c_token_classifier_unit_defines.svh"

module ctc_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  ctc_pkg::ctc_req_type  req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ctc_pkg::ctc_rsp_type  rsp_word
);
   import ctc_pkg::*;

   `CTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result word changed")

   `CTC_ASSERT_NOW(a_class_range, rsp_valid, rsp_word.token_class <= CLASS_OPERATOR, "token class out of range")

   `CTC_ASSERT_NOW(a_unused_zero, rsp_valid, ((rsp_word.token_class == CLASS_KEYWORD) || (rsp_word.keyword_number == 5'd0)) && ((rsp_word.token_class == CLASS_OPERATOR) || (rsp_word.operator_code == 4'd0)), "unused result field not zero")

   `CTC_ASSERT_NOW(a_length, rsp_valid && (req_valid || !req_valid || req_stall || req_word.end_of_input || !req_word.end_of_input), ((rsp_word.token_class != CLASS_OPERATOR) || (rsp_word.token_length == 8'd1) || (rsp_word.token_length == 8'd2)) && (rsp_word.token_length != 8'd0), "result length inconsistent with class")

endmodule

bind c_token_classifier_unit ctc_checker u_ctc_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token classifier testbench
// Streams C-like source text into the classifier and checks every result word
// against a software lexer kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
// The lexer below mirrors the block's splitting rules. It runs on every byte
// the block accepts and queues the tokens that byte should produce. The
// receiving process pops the oldest queued token for each result word and
// compares it field by field. Test tasks cover:
//    hand-written text that touches every class, separator and operator pair;
//    all nineteen keywords;
//    a token long enough to saturate the length counter;
//    random text under three idling mixes.
// ----------------------------------------------------------------------------
module tb;
   import ctc_pkg::*;

   localparam int QUIET_LIMIT  = 5000;   // cycles with no word moving
   localparam int DRAIN_CYCLES = 20;     // settling time once the queue is empty

   // Character classes as the lexer sees them.
   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_LETTER,
      KIND_UNDERSCORE,
      KIND_SEPARATOR,
      KIND_OPERATOR,
      KIND_OTHER
   } char_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ctc_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ctc_rsp_type rsp_word;

   // Idling percentages for the sending and receiving sides.
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;

   int bytes_sent   = 0;
   int tokens_seen  = 0;
   int mismatches   = 0;
   int quiet_cycles = 0;

   // Tokens the lexer has produced that the block has not yet delivered.
   ctc_rsp_type token_queue[$];
   // Tokens produced by the byte currently being lexed.
   ctc_rsp_type step_words[$];

   // Lexer state. Only the first eight bytes of a token are kept, as no
   // keyword is longer than seven.
   logic [7:0]  lex_len    = 8'd0;
   logic [15:0] lex_start  = 16'd0;
   logic [15:0] lex_pos    = 16'd0;
   logic        lex_digits = 1'b1;
   logic        lex_ident  = 1'b1;
   logic [7:0]  lex_text [8];
   logic        held_valid = 1'b0;
   logic [2:0]  held_op    = 3'd0;
   logic [15:0] held_start = 16'd0;

   logic [7:0] separator_chars [11] = '{CH_SPACE, CH_TAB, CH_NEWLINE, CH_COMMA,
      CH_SEMICOLON, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET,
      CH_RBRACKET};
   logic [7:0] operator_chars [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
      CH_EQUAL, CH_GREATER, CH_LESS, CH_BANG};

   c_token_classifier_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Lexer
   // -------------------------------------------------------------------------

   function automatic string keyword_spelling(input int k);
      case (k)
         0:       return "int";
         1:       return "float";
         2:       return "if";
         3:       return "else";
         4:       return "while";
         5:       return "for";
         6:       return "do";
         7:       return "return";
         8:       return "break";
         9:       return "switch";
         10:      return "case";
         11:      return "char";
         12:      return "double";
         13:      return "void";
         14:      return "long";
         15:      return "short";
         16:      return "struct";
         17:      return "typedef";
         18:      return "static";
         default: return "";
      endcase
   endfunction

   function automatic char_kind_type kind_of(input logic [7:0] c);
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         return KIND_DIGIT;
      end
      if ((c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)) begin
         return KIND_LETTER;
      end
      case (c)
         CH_UNDERSCORE: begin
            return KIND_UNDERSCORE;
         end
         CH_SPACE, CH_TAB, CH_NEWLINE, CH_COMMA, CH_SEMICOLON, CH_LPAREN,
         CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET: begin
            return KIND_SEPARATOR;
         end
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL, CH_GREATER, CH_LESS,
         CH_BANG: begin
            return KIND_OPERATOR;
         end
         default: begin
            return KIND_OTHER;
         end
      endcase
   endfunction

   function automatic logic [2:0] single_op(input logic [7:0] c);
      case (c)
         CH_MINUS:   return OP_MINUS;
         CH_STAR:    return OP_STAR;
         CH_SLASH:   return OP_SLASH;
         CH_EQUAL:   return OP_EQUAL;
         CH_GREATER: return OP_GREATER;
         CH_LESS:    return OP_LESS;
         CH_BANG:    return OP_BANG;
         default:    return OP_PLUS;
      endcase
   endfunction

   // Classifies the open token, queues it and starts a fresh one.
   task automatic close_token();
      ctc_rsp_type w;
      string       spell;
      int          k;
      int          i;
      logic        same;
      logic        found;
      w = '0;
      found = 1'b0;
      // A keyword needs the exact spelling, so a saturated token never matches.
      for (k = 0; k < NUM_KEYWORDS; k++) begin
         spell = keyword_spelling(k);
         same = !found && (lex_len == 8'(spell.len()));
         for (i = 0; same && i < spell.len(); i++) begin
            same = (lex_text[i] == spell[i]);
         end
         if (same) begin
            found = 1'b1;
            w.keyword_number = 5'(k);
         end
      end
      if (found) begin
         w.token_class = CLASS_KEYWORD;
      end else if (lex_digits) begin
         w.token_class = CLASS_INTEGER;
      end else if (lex_ident) begin
         w.token_class = CLASS_IDENTIFIER;
      end else begin
         w.token_class = CLASS_UNIDENTIFIED;
      end
      w.token_start  = lex_start;
      w.token_length = lex_len;
      step_words.push_back(w);
      lex_len    = 8'd0;
      lex_digits = 1'b1;
      lex_ident  = 1'b1;
   endtask

   // Queues the held single-character operator.
   task automatic release_operator();
      ctc_rsp_type w;
      w = '0;
      w.token_class   = CLASS_OPERATOR;
      w.operator_code = {1'b0, held_op};
      w.token_start   = held_start;
      w.token_length  = 8'd1;
      step_words.push_back(w);
      held_valid = 1'b0;
   endtask

   // Runs one accepted byte through the lexer and queues what it produces,
   // marking the last of them.
   task automatic lex_char(input logic [7:0] c, input logic eoi);
      ctc_rsp_type   w;
      char_kind_type kind;
      logic          taken;
      logic          pairs;
      int            i;
      step_words.delete();
      taken = 1'b0;
      kind  = kind_of(c);

      if (held_valid) begin
         w = '0;
         w.token_class  = CLASS_OPERATOR;
         w.token_start  = held_start;
         w.token_length = 8'd2;
         pairs = 1'b1;
         case (held_op)
            OP_EQUAL:   w.operator_code = OP_EQ_EQ;
            OP_BANG:    w.operator_code = OP_NOT_EQ;
            OP_GREATER: w.operator_code = OP_GREATER_EQ;
            OP_LESS:    w.operator_code = OP_LESS_EQ;
            default:    pairs = 1'b0;
         endcase
         if (pairs && c == CH_EQUAL) begin
            step_words.push_back(w);
            held_valid = 1'b0;
            taken = 1'b1;
         end else begin
            release_operator();
         end
      end

      if (!taken) begin
         case (kind)
            KIND_SEPARATOR: begin
               if (lex_len != 8'd0) begin
                  close_token();
               end
            end
            KIND_OPERATOR: begin
               if (lex_len != 8'd0) begin
                  close_token();
               end
               held_valid = 1'b1;
               held_op    = single_op(c);
               held_start = lex_pos;
            end
            default: begin
               if (lex_len == 8'd0) begin
                  lex_start = lex_pos;
                  lex_ident = (kind == KIND_LETTER) || (kind == KIND_UNDERSCORE);
               end else if (kind == KIND_OTHER) begin
                  lex_ident = 1'b0;
               end
               if (kind != KIND_DIGIT) begin
                  lex_digits = 1'b0;
               end
               if (lex_len < 8'd8) begin
                  lex_text[lex_len[2:0]] = c;
               end
               if (lex_len < LEN_LIMIT) begin
                  lex_len++;
               end
            end
         endcase
      end

      if (eoi) begin
         if (lex_len != 8'd0) begin
            close_token();
         end
         if (held_valid) begin
            release_operator();
         end
         lex_pos    = 16'd0;
         lex_start  = 16'd0;
         held_op    = 3'd0;
         held_start = 16'd0;
      end else begin
         lex_pos++;
      end

      for (i = 0; i < step_words.size(); i++) begin
         w = step_words[i];
         w.last_of_run = (i == step_words.size() - 1);
         token_queue.push_back(w);
      end
   endtask

   // -------------------------------------------------------------------------
   // Sending side
   // -------------------------------------------------------------------------

   // Offers one byte after a random gap and waits for the block to take it.
   // Valid stays high between back-to-back words.
   task automatic send_char(input logic [7:0] c, input logic eoi);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{char_code: c, end_of_input: eoi};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
      lex_char(c, eoi);
   endtask

   task automatic send_text(input string s, input logic eoi_last);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_char(s[i], eoi_last && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] random_word_char();
      case ($urandom_range(0, 3))
         0:       return CH_LOWER_A + 8'($urandom_range(0, 25));
         1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
         2:       return CH_DIGIT_0 + 8'($urandom_range(0, 9));
         default: return CH_UNDERSCORE;
      endcase
   endfunction

   // Sends one random lexical piece: mostly well-formed tokens, operators and
   // separators, with some near-miss keywords and raw noise bytes.
   task automatic send_random_piece(input logic eoi_allowed);
      logic [7:0] piece[$];
      logic [7:0] first;
      string      spell;
      int         pick;
      int         n;
      int         i;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         spell = keyword_spelling($urandom_range(0, NUM_KEYWORDS - 1));
         for (i = 0; i < spell.len(); i++) begin
            piece.push_back(spell[i]);
         end
      end else if (pick < 28) begin
         // A keyword cut short, or run on by one more word character.
         spell = keyword_spelling($urandom_range(0, NUM_KEYWORDS - 1));
         n = $urandom_range(0, 1) ? $urandom_range(1, spell.len() - 1) : spell.len();
         for (i = 0; i < n; i++) begin
            piece.push_back(spell[i]);
         end
         if (n == spell.len()) begin
            piece.push_back(random_word_char());
         end
      end else if (pick < 45) begin
         do begin
            first = random_word_char();
         end while (first >= CH_DIGIT_0 && first <= CH_DIGIT_9);
         piece.push_back(first);
         n = $urandom_range(0, 8);
         for (i = 0; i < n; i++) begin
            piece.push_back(random_word_char());
         end
      end else if (pick < 57) begin
         n = $urandom_range(1, 5);
         for (i = 0; i < n; i++) begin
            piece.push_back(CH_DIGIT_0 + 8'($urandom_range(0, 9)));
         end
      end else if (pick < 75) begin
         piece.push_back(operator_chars[$urandom_range(0, 7)]);
         if ($urandom_range(0, 1)) begin
            piece.push_back(CH_EQUAL);
         end
      end else if (pick < 90) begin
         piece.push_back(separator_chars[$urandom_range(0, 10)]);
      end else begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++) begin
            piece.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (i = 0; i < piece.size(); i++) begin
         send_char(piece[i], eoi_allowed && (i == piece.size() - 1) &&
                   ($urandom_range(0, 11) == 0));
      end
   endtask

   task automatic set_idling(input int gap_pct, input int stall_pct);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Hand-written text: every separator, integers, identifiers, an
   // unidentified token of NUL and non-ASCII bytes, all single and paired
   // operators, and the flushes that end of input forces, including the case
   // where one byte yields a held operator and a token together.
   task automatic test_basic_tokens();
      send_text("do,_9 42\t9z\n(a)[b]{c};", 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("q a+-*/==!=>=<=><", 1'b0);
      send_text(" =k", 1'b1);
      send_text("b!", 1'b1);
      send_text("=", 1'b1);
   endtask

   // Every keyword once, in list order, so each keyword number is seen.
   task automatic test_keyword_table();
      string spell;
      int    k;
      int    i;
      for (k = 0; k < NUM_KEYWORDS; k++) begin
         spell = keyword_spelling(k);
         for (i = 0; i < spell.len(); i++) begin
            send_char(spell[i], 1'b0);
         end
         send_char(separator_chars[$urandom_range(0, 10)], k == NUM_KEYWORDS - 1);
      end
   endtask

   // An identifier that runs past the length limit. It starts with a keyword
   // spelling and is closed by end of input.
   task automatic test_saturation();
      int i;
      send_text("while", 1'b0);
      for (i = 0; i < 253; i++) begin
         send_char(random_word_char(), i == 252);
      end
   endtask

   task automatic test_random_text(input int count);
      int first_byte;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < count) begin
         send_random_piece(1'b1);
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiving side and checking
   // -------------------------------------------------------------------------

   task automatic note_failure(input string what, input ctc_rsp_type want,
                               input ctc_rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected class %0d kw %0d op %0d start %0d len %0d last %0d",
                  $realtime, what, want.token_class, want.keyword_number,
                  want.operator_code, want.token_start, want.token_length,
                  want.last_of_run);
         $display("      got class %0d kw %0d op %0d start %0d len %0d last %0d",
                  got.token_class, got.keyword_number, got.operator_code,
                  got.token_start, got.token_length, got.last_of_run);
      end
   endtask

   // Each accepted result word is matched against the oldest queued token.
   // The stall for the next edge is drawn after the current one is sampled.
   always @(posedge clock) begin : result_check
      ctc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_seen++;
         if (token_queue.size() == 0) begin
            note_failure("word with no token queued", '0, rsp_word);
         end else begin
            want = token_queue.pop_front();
            if (rsp_word.token_class !== want.token_class ||
                rsp_word.keyword_number !== want.keyword_number ||
                rsp_word.operator_code !== want.operator_code ||
                rsp_word.token_start !== want.token_start ||
                rsp_word.token_length !== want.token_length ||
                rsp_word.last_of_run !== want.last_of_run) begin
               note_failure("token mismatch", want, rsp_word);
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Ends a run in which no word has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timed out with %0d tokens outstanding.", token_queue.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence of tests
   // -------------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles a little, receiver stalls heavily.
      set_idling(22, 75);
      test_basic_tokens();
      test_keyword_table();
      test_random_text(45);

      // Sender idles heavily, receiver stalls a little.
      set_idling(75, 22);
      test_saturation();
      test_random_text(45);

      // Back-to-back traffic on both sides.
      set_idling(0, 0);
      test_random_text(45);

      req_valid <= 1'b0;
      while (token_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Lexed %0d source bytes into %0d result words; %0d words were wrong.",
               bytes_sent, tokens_seen, mismatches);
      $display("Covered all keywords, operator pairs, a saturated token and three idling mixes.");
      if (mismatches == 0 && token_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
